// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SRIG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srig: implication check failed");

// Condition must never be seen outside reset
`define SRIG_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("srig: forbidden condition seen");

`endif

// File: hdl/srig_pkg.sv
package srig_pkg;

    // Ramp table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    // Scaled ticks per timer tick, a power of two
    localparam int SCALE_FACTOR = 16;
    localparam int SCALE_SHIFT  = $clog2(SCALE_FACTOR);

    // Timer period has the form 2^n - 1, so the split uses an end-around fold
    localparam int TIMER_BITS   = 16;
    localparam int TIMER_PERIOD = (2 ** TIMER_BITS) - 1;

    // Step pulse width in timer ticks
    localparam int PULSE_TICKS = 400;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    // Operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // Phase codes
    localparam logic [1:0] PHASE_ACCEL  = 2'd0;
    localparam logic [1:0] PHASE_CRUISE = 2'd1;
    localparam logic [1:0] PHASE_DECEL  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ACCEL_END   = 3'd0;
    localparam logic [2:0] CFG_DECEL_START = 3'd1;
    localparam logic [2:0] CFG_ACCEL_IDX   = 3'd2;
    localparam logic [2:0] CFG_DECEL_IDX   = 3'd3;
    localparam logic [2:0] CFG_TARGET      = 3'd4;
    localparam logic [2:0] CFG_ACCEL_SIGN  = 3'd5;
    localparam logic [2:0] CFG_DECEL_SIGN  = 3'd6;
    localparam logic [2:0] CFG_NO_RAMP     = 3'd7;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  table_index;
        logic [30:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  phase;
        logic [30:0] scaled_interval;
        logic [30:0] hw_count;
        logic [30:0] full_rounds;
        logic [15:0] remainder_ticks;
        logic [47:0] elapsed_ticks;
        logic [15:0] overshoot_accel_count;
        logic [15:0] overshoot_decel_count;
        logic [31:0] step_index;
    } t_out_item;

    typedef struct packed {
        logic [31:0]        accel_end_step;
        logic [31:0]        decel_start_step;
        logic signed [10:0] accel_start_index;
        logic signed [10:0] decel_start_index;
        logic [30:0]        target_interval;
        logic signed [1:0]  accel_sign;
        logic signed [1:0]  decel_sign;
        logic               no_ramp;
    } t_cfg;

    // Decoded item kind as it sits in the queue
    typedef enum logic [1:0] {
        KIND_START,
        KIND_STEP,
        KIND_LOAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TBL_AW-1:0]  addr;
        logic [30:0]        value;
    } t_cmd;

    // Back end to output stage
    typedef struct packed {
        logic        start;
        logic        step;
        logic [1:0]  phase;
        logic [30:0] interval;
        logic [30:0] hw;
        logic [31:0] step_idx;
        logic [15:0] acc_ov;
        logic [15:0] dec_ov;
    } t_mid;

endpackage

// File: hdl/srig_front.sv
module srig_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  srig_pkg::t_in_item i_in_item,
    output logic              o_cmd_valid,
    output srig_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import srig_pkg::*;

    t_cmd           r_queue [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    logic w_full;
    logic w_accept;
    logic w_keep;
    logic w_push;
    logic w_pop;
    t_cmd w_cmd;

    assign w_full   = (r_count == (QAW + 1)'(QUEUE_DEPTH));
    assign w_accept = i_in_valid && !w_full;
    assign w_pop    = i_cmd_pop && (r_count != '0);
    assign w_push   = w_accept && w_keep;

    // Classify: unused codes and out-of-range loads are dropped here
    always_comb begin
        w_keep     = 1'b1;
        w_cmd.kind = KIND_STEP;
        w_cmd.addr = TBL_AW'(32'(i_in_item.table_index));
        w_cmd.value = i_in_item.table_value;
        unique case (i_in_item.operation)
            OP_START: w_cmd.kind = KIND_START;
            OP_STEP:  w_cmd.kind = KIND_STEP;
            OP_LOAD: begin
                w_cmd.kind = KIND_LOAD;
                w_keep     = (32'(i_in_item.table_index) < 32'(TABLE_DEPTH));
            end
            default:  w_keep = 1'b0;
        endcase
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_in_stall  = w_full;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

endmodule

// File: hdl/srig_back.sv
module srig_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srig_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  srig_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_adv,
    output srig_pkg::t_mid o_mid
);
    import srig_pkg::*;

    // Ramp table, contents undefined until loaded
    logic [30:0] r_table [TABLE_DEPTH];

    // Issue stage state
    logic [31:0] r_step_cnt;
    logic [31:0] r_ramp_index;

    // Lookup stage registers
    logic        r1_valid;
    t_kind       r1_kind;
    logic [1:0]  r1_phase;
    logic [31:0] r1_step;
    logic [30:0] r_rd_data;

    // Interval state
    logic [30:0] r_cur_interval;
    logic [15:0] r_acc_ov;
    logic [15:0] r_dec_ov;
    t_mid        r_mid;

    logic              w_pop;
    logic              w_is_step;
    logic              w_accel;
    logic              w_decel;
    logic [31:0]       w_idx;
    logic [31:0]       w_mag;
    logic [TBL_AW-1:0] w_rd_addr;
    logic [1:0]        w_phase;

    logic [30:0] w_tv;
    logic        w_gt;
    logic        w_lt;
    logic        w_acc_fail;
    logic        w_dec_fail;
    logic [30:0] n_cur_interval;
    logic [15:0] n_acc_ov;
    logic [15:0] n_dec_ov;

    assign w_pop     = i_adv && i_cmd_valid;
    assign w_is_step = (i_cmd.kind == KIND_STEP);

    // Phase select and ramp index reload at phase start
    always_comb begin
        w_accel = (r_step_cnt < i_cfg.accel_end_step);
        w_decel = !w_accel && (r_step_cnt >= i_cfg.decel_start_step);
        w_idx   = r_ramp_index;
        priority if (w_accel) begin
            w_phase = PHASE_ACCEL;
            if (r_step_cnt == '0) begin
                w_idx = 32'(i_cfg.accel_start_index);
            end
        end else if (w_decel) begin
            w_phase = PHASE_DECEL;
            if (r_step_cnt == i_cfg.decel_start_step) begin
                w_idx = 32'(i_cfg.decel_start_index);
            end
        end else begin
            w_phase = PHASE_CRUISE;
        end
        // table address is |index| clamped to the last entry
        w_mag = w_idx[31] ? (32'd0 - w_idx) : w_idx;
        if (w_mag > 32'(TABLE_DEPTH - 1)) begin
            w_rd_addr = TBL_AW'(TABLE_DEPTH - 1);
        end else begin
            w_rd_addr = w_mag[TBL_AW-1:0];
        end
    end

    // Table write on load, registered read for every issued item
    always_ff @(posedge i_clk) begin
        if (w_pop && (i_cmd.kind == KIND_LOAD)) begin
            r_table[i_cmd.addr] <= i_cmd.value;
        end
        if (i_adv) begin
            r_rd_data <= r_table[w_rd_addr];
        end
    end

    // Issue stage: step counter, ramp index, lookup handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cnt   <= '0;
            r_ramp_index <= '0;
            r1_valid     <= 1'b0;
            r1_kind      <= KIND_START;
        end else if (i_adv) begin
            r1_valid <= w_pop;
            r1_kind  <= i_cmd.kind;
            if (w_pop && (i_cmd.kind == KIND_START)) begin
                r_step_cnt <= '0;
            end
            if (w_pop && w_is_step) begin
                if (r_step_cnt != '1) begin
                    r_step_cnt <= r_step_cnt + 1'b1;
                end
                if (w_accel || w_decel) begin
                    r_ramp_index <= (w_idx == 32'h7FFF_FFFF) ? w_idx : (w_idx + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_phase <= w_phase;
            r1_step  <= r_step_cnt;
        end
    end

    // Overshoot guard and interval choice
    always_comb begin
        w_tv = i_cfg.no_ramp ? i_cfg.target_interval : r_rd_data;
        w_gt = (w_tv > i_cfg.target_interval);
        w_lt = (w_tv < i_cfg.target_interval);
        // table minus target against accel sign
        w_acc_fail = (w_gt && i_cfg.accel_sign[1]) || (w_lt && (i_cfg.accel_sign == 2'sd1));
        // target minus table against decel sign
        w_dec_fail = (w_lt && i_cfg.decel_sign[1]) || (w_gt && (i_cfg.decel_sign == 2'sd1));

        n_cur_interval = r_cur_interval;
        n_acc_ov       = r_acc_ov;
        n_dec_ov       = r_dec_ov;
        unique case (r1_phase)
            PHASE_ACCEL: begin
                if (w_acc_fail) begin
                    n_cur_interval = i_cfg.target_interval;
                    if (r_acc_ov != '1) begin
                        n_acc_ov = r_acc_ov + 1'b1;
                    end
                end else begin
                    n_cur_interval = w_tv;
                end
            end
            PHASE_DECEL: begin
                if (w_dec_fail) begin
                    if (r_dec_ov != '1) begin
                        n_dec_ov = r_dec_ov + 1'b1;
                    end
                end else begin
                    n_cur_interval = w_tv;
                end
            end
            default: n_cur_interval = i_cfg.target_interval;
        endcase
    end

    // Interval stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_interval <= '0;
            r_acc_ov       <= '0;
            r_dec_ov       <= '0;
            r_mid          <= '0;
        end else if (i_adv) begin
            r_mid.start    <= r1_valid && (r1_kind == KIND_START);
            r_mid.step     <= r1_valid && (r1_kind == KIND_STEP);
            r_mid.phase    <= r1_phase;
            r_mid.interval <= n_cur_interval;
            r_mid.hw       <= n_cur_interval >> SCALE_SHIFT;
            r_mid.step_idx <= r1_step;
            r_mid.acc_ov   <= n_acc_ov;
            r_mid.dec_ov   <= n_dec_ov;
            if (r1_valid && (r1_kind == KIND_START)) begin
                r_acc_ov <= '0;
                r_dec_ov <= '0;
            end
            if (r1_valid && (r1_kind == KIND_STEP)) begin
                r_cur_interval <= n_cur_interval;
                r_acc_ov       <= n_acc_ov;
                r_dec_ov       <= n_dec_ov;
            end
        end
    end

    assign o_cmd_pop = w_pop;
    assign o_mid     = r_mid;

endmodule

// File: hdl/srig_split.sv
module srig_split (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srig_pkg::t_mid     i_mid,
    output logic               o_adv,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srig_pkg::t_out_item o_out_item
);
    import srig_pkg::*;

    logic        r_out_valid;
    t_out_item   r_out;
    logic [47:0] r_elapsed;

    logic                w_adv;
    logic                w_long;
    logic [30:0]         w_d;
    logic [30:0]         w_q0;
    logic [TIMER_BITS:0] w_r0;
    logic                w_wrap;
    logic [30:0]         w_rounds;
    logic [15:0]         w_rem;
    logic [48:0]         w_sum;
    logic [47:0]         n_elapsed;

    assign w_adv = !r_out_valid || !i_out_stall;

    // Split hw - pulse into periods of 2^n - 1: fold high part onto low part
    always_comb begin
        w_long = (i_mid.hw >= 31'(PULSE_TICKS));
        w_d    = i_mid.hw - 31'(PULSE_TICKS);
        w_q0   = w_d >> TIMER_BITS;
        w_r0   = (TIMER_BITS + 1)'(w_d[TIMER_BITS-1:0])
               + (TIMER_BITS + 1)'(w_q0);
        w_wrap = (w_r0 >= (TIMER_BITS + 1)'(TIMER_PERIOD));
        if (!w_long) begin
            w_rounds = '0;
            w_rem    = '0;
        end else if (w_wrap) begin
            w_rounds = w_q0 + 1'b1;
            w_rem    = 16'(w_r0 - (TIMER_BITS + 1)'(TIMER_PERIOD));
        end else begin
            w_rounds = w_q0;
            w_rem    = 16'(w_r0);
        end
    end

    // Saturating running sum of timer ticks
    always_comb begin
        w_sum     = {1'b0, r_elapsed} + 49'(i_mid.hw);
        n_elapsed = w_sum[48] ? '1 : w_sum[47:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_elapsed   <= '0;
        end else if (w_adv) begin
            r_out_valid <= i_mid.step;
            if (i_mid.start) begin
                r_elapsed <= '0;
            end
            if (i_mid.step) begin
                r_elapsed <= n_elapsed;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_adv && i_mid.step) begin
            r_out.phase                 <= i_mid.phase;
            r_out.scaled_interval       <= i_mid.interval;
            r_out.hw_count              <= i_mid.hw;
            r_out.full_rounds           <= w_rounds;
            r_out.remainder_ticks       <= w_rem;
            r_out.elapsed_ticks         <= n_elapsed;
            r_out.overshoot_accel_count <= i_mid.acc_ov;
            r_out.overshoot_decel_count <= i_mid.dec_ov;
            r_out.step_index            <= i_mid.step_idx;
        end
    end

    assign o_adv       = w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: hdl/stepper_ramp_interval_generator_top.sv
// Stepper ramp interval generator. Items are accepted one per cycle into a
// four-entry queue (stall rises only when it is full) and leave it at one per
// cycle, so the sustained rate is one item per clock whenever the result side
// keeps up; an item passes through the queue, lookup stage, interval stage and
// result register. The pace is set by the back end, which takes one item from
// the queue per cycle (the 1024 x 31 ramp table does one load write and one
// lookup read in that cycle), and by the result register, which holds the
// whole back end while a result waits. Start and load items return no result,
// nor does operation code 3. Table entries read before they are loaded are
// undefined. Configuration writes are always ready and take effect at once;
// change them only while no item is in flight.
`include "assert_macros.svh"

module stepper_ramp_interval_generator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  srig_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output srig_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import srig_pkg::*;

    t_cfg r_cfg;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;
    logic w_adv;
    t_mid w_mid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_end_step    <= '0;
            r_cfg.decel_start_step  <= '0;
            r_cfg.accel_start_index <= '0;
            r_cfg.decel_start_index <= '0;
            r_cfg.target_interval   <= '0;
            r_cfg.accel_sign        <= 2'sd1;
            r_cfg.decel_sign        <= 2'sd1;
            r_cfg.no_ramp           <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACCEL_END:   r_cfg.accel_end_step    <= i_cfg_data;
                CFG_DECEL_START: r_cfg.decel_start_step  <= i_cfg_data;
                CFG_ACCEL_IDX:   r_cfg.accel_start_index <= i_cfg_data[10:0];
                CFG_DECEL_IDX:   r_cfg.decel_start_index <= i_cfg_data[10:0];
                CFG_TARGET:      r_cfg.target_interval   <= i_cfg_data[30:0];
                CFG_ACCEL_SIGN:  r_cfg.accel_sign        <= i_cfg_data[1:0];
                CFG_DECEL_SIGN:  r_cfg.decel_sign        <= i_cfg_data[1:0];
                CFG_NO_RAMP:     r_cfg.no_ramp           <= i_cfg_data[0];
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    srig_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    srig_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_adv       (w_adv),
        .o_mid       (w_mid)
    );

    srig_split u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid       (w_mid),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Back end only pops a queue that holds an item, and only when it may advance
    `SRIG_ASSERT_IMPLIES(a_pop_has_item, i_clk, i_rst_n, w_cmd_pop, w_cmd_valid && w_adv)
    // Short intervals give no rounds and no remainder
    `SRIG_ASSERT_IMPLIES(a_short_split, i_clk, i_rst_n, o_out_valid && (o_out_item.hw_count < 31'(PULSE_TICKS)), (o_out_item.full_rounds == '0) && (o_out_item.remainder_ticks == '0))
    // Cruise results always carry the target interval
    `SRIG_ASSERT_IMPLIES(a_cruise_target, i_clk, i_rst_n, o_out_valid && (o_out_item.phase == PHASE_CRUISE), o_out_item.scaled_interval == r_cfg.target_interval)
    // Remainder stays below the timer period
    `SRIG_ASSERT_NEVER(a_rem_range, i_clk, i_rst_n, o_out_valid && (32'(o_out_item.remainder_ticks) >= 32'(TIMER_PERIOD)))

endmodule
